>>> rtl/core/brb_pkg.sv
package brb_pkg;

  localparam int DEPTH_DEF   = 1024;
  localparam int LANES_DEF   = 8;
  localparam int CNT_FIELD_W = 4;

  typedef enum logic [1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DEQ   = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_CLEAR = 2'd3
  } brb_cmd_t;

  // Outcome of one command against the current pointers.
  typedef struct packed {
    logic ok;     // command carried out
    logic wr_en;  // bytes go into the store
    logic rd_en;  // bytes come out of the store (dequeue or peek)
  } brb_dec_t;

endpackage

>>> rtl/core/brb_bank.sv
module brb_bank #(
  parameter int ROWS  = 128,
  parameter int ROW_W = 7
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ROW_W-1:0] waddr,
  input  logic [7:0]       wdata,
  input  logic             re,
  input  logic [ROW_W-1:0] raddr,
  output logic [7:0]       rdata
);

  logic [7:0] mem [ROWS];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold the last read word until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/brb_ctrl.sv
module brb_ctrl
  import brb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int LANES = LANES_DEF,
  localparam int PTR_W = $clog2(DEPTH) + 1,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   acc,
  input  brb_cmd_t               cmd,
  input  logic [CNT_FIELD_W-1:0] count,
  output logic [PTR_W-1:0]       rd_ptr,
  output logic [PTR_W-1:0]       wr_ptr,
  output brb_dec_t               dec,
  output logic [PTR_W-1:0]       used_nxt,
  output logic [PTR_W-1:0]       free_nxt,
  output logic [PTR_W-1:0]       cfree_nxt,
  output logic [PTR_W-1:0]       cused_nxt
);

  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] used, free;
  logic [PTR_W-1:0] room_w, room_r;

  always_comb begin
    used       = wr_ptr_r - rd_ptr_r;
    free       = PTR_W'(DEPTH) - used;
    dec        = '0;
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    priority if (cmd == CMD_CLEAR) begin
      dec.ok     = 1'b1;
      rd_ptr_nxt = '0;
      wr_ptr_nxt = '0;
    end else if (count == '0) begin
      dec.ok = 1'b1;
    end else if (int'(count) > LANES) begin
      dec.ok = 1'b0;
    end else if (cmd == CMD_ENQ) begin
      if (32'(free) >= 32'(count)) begin
        dec.ok     = 1'b1;
        dec.wr_en  = 1'b1;
        wr_ptr_nxt = wr_ptr_r + PTR_W'(count);
      end
    end else begin
      if (32'(used) >= 32'(count)) begin
        dec.ok    = 1'b1;
        dec.rd_en = 1'b1;
        if (cmd == CMD_DEQ) begin
          rd_ptr_nxt = rd_ptr_r + PTR_W'(count);
        end
      end
    end
  end

  // Occupancy after the command, and room up to the wrap point.
  always_comb begin
    used_nxt  = wr_ptr_nxt - rd_ptr_nxt;
    free_nxt  = PTR_W'(DEPTH) - used_nxt;
    room_w    = PTR_W'(DEPTH) - PTR_W'(wr_ptr_nxt[IDX_W-1:0]);
    room_r    = PTR_W'(DEPTH) - PTR_W'(rd_ptr_nxt[IDX_W-1:0]);
    cfree_nxt = (free_nxt < room_w) ? free_nxt : room_w;
    cused_nxt = (used_nxt < room_r) ? used_nxt : room_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
    end else if (acc) begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
    end
  end

  assign rd_ptr = rd_ptr_r;
  assign wr_ptr = wr_ptr_r;

endmodule

>>> rtl/core/brb_align.sv
module brb_align
  import brb_pkg::*;
#(
  parameter int NB    = 8,
  parameter int SEL_W = 3,
  parameter int LANES = LANES_DEF
) (
  input  logic [NB*8-1:0]        bank_data,
  input  logic [SEL_W-1:0]       rot,
  input  logic [CNT_FIELD_W-1:0] count,
  input  logic                   rd_en,
  output logic [8*LANES-1:0]     read_bytes
);

  // Lane i comes from the bank that holds read_pointer + i; drop lanes past count.
  always_comb begin
    logic [SEL_W-1:0] sel;
    read_bytes = '0;
    for (int i = 0; i < LANES; i++) begin
      sel = SEL_W'((int'(rot) + i) % NB);
      if (rd_en && (i < int'(count))) begin
        read_bytes[8*i +: 8] = bank_data[8*int'(sel) +: 8];
      end
    end
  end

endmodule

>>> rtl/core/byte_ring_buffer_unit.sv
// Channel | dir | handshake             | contents
// --------+-----+-----------------------+-------------------------------------------
// in_     | in  | in_tvalid/in_tready   | tuser: cmd; tdata: byte_count, write_bytes
// out_    | out | out_tvalid/out_tready | tuser: accepted; tdata: read_bytes, counts
//
// One word per cycle sustained while the output is not stalled; a taken word's result
// is registered first in the bank read register, then in the output register.
// Reset clears both pointers and the pipeline valids; the byte store is not cleared.
// A stalled result holds in the output register while one more word is taken
// into the middle stage; in_tready drops only when both stages are full and stalled.
module byte_ring_buffer_unit
  import brb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int LANES = LANES_DEF,
  localparam int CNT_W    = $clog2(DEPTH) + 1,
  localparam int DW       = 8 * LANES,
  localparam int IN_TD_W  = ((CNT_FIELD_W + DW + 7) / 8) * 8,
  localparam int OUT_TD_W = ((DW + 4 * CNT_W + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [1:0]          in_tuser,   // cmd
  input  logic [IN_TD_W-1:0]  in_tdata,   // byte_count, write_bytes, zero pad
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic                out_tuser,  // accepted
  output logic [OUT_TD_W-1:0] out_tdata   // read_bytes, used_count, free_count,
                                          // contiguous_free, contiguous_used, zero pad
);

  // Store is split into NB byte banks so any LANES consecutive bytes hit distinct banks.
  localparam int NB_P2 = 1 << $clog2(LANES);
  localparam int NB    = (NB_P2 < DEPTH) ? NB_P2 : DEPTH;
  localparam int ROWS  = DEPTH / NB;
  localparam int SEL_W = (NB > 1) ? $clog2(NB) : 1;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic                   in_acc;
  brb_cmd_t               in_cmd;
  logic [CNT_FIELD_W-1:0] in_count;
  logic [DW-1:0]          wr_data;

  logic [CNT_W-1:0] rd_ptr, wr_ptr, base;
  logic [SEL_W-1:0] base_lo;
  brb_dec_t         dec;
  logic [CNT_W-1:0] used_nxt, free_nxt, cfree_nxt, cused_nxt;
  logic [NB*8-1:0]  bank_data;

  // Middle stage: decision and counts wait here beside the bank read data.
  logic                   s1_v_r;
  logic                   s1_ok_r;
  logic                   s1_rd_r;
  logic [SEL_W-1:0]       s1_rot_r;
  logic [CNT_FIELD_W-1:0] s1_count_r;
  logic [CNT_W-1:0]       s1_used_r, s1_free_r, s1_cfree_r, s1_cused_r;
  logic                   s1_move;

  // Output register.
  logic             out_v_r;
  logic             out_ok_r;
  logic [DW-1:0]    out_rd_r;
  logic [CNT_W-1:0] out_used_r, out_free_r, out_cfree_r, out_cused_r;
  logic [DW-1:0]    rd_aligned;

  assign in_cmd   = brb_cmd_t'(in_tuser);
  assign in_count = in_tdata[CNT_FIELD_W-1:0];
  assign wr_data  = in_tdata[CNT_FIELD_W +: DW];

  // Advance the middle stage when the output register is free or being drained.
  assign s1_move   = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_move;
  assign in_acc    = in_tvalid && in_tready;

  brb_ctrl #(
    .DEPTH (DEPTH),
    .LANES (LANES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .cmd       (in_cmd),
    .count     (in_count),
    .rd_ptr    (rd_ptr),
    .wr_ptr    (wr_ptr),
    .dec       (dec),
    .used_nxt  (used_nxt),
    .free_nxt  (free_nxt),
    .cfree_nxt (cfree_nxt),
    .cused_nxt (cused_nxt)
  );

  // Writes start at the write pointer, reads at the read pointer.
  assign base    = dec.wr_en ? wr_ptr : rd_ptr;
  assign base_lo = SEL_W'(base % NB);

  for (genvar b = 0; b < NB; b++) begin : g_bank
    logic [SEL_W-1:0] off;
    logic [ROW_W-1:0] row;
    logic             we;
    logic             re;
    logic [7:0]       wbyte;

    // Bank b holds byte number off of this access; banks below the base
    // offset belong to the next row.
    always_comb begin
      off   = SEL_W'((b + NB - int'(base_lo)) % NB);
      row   = ROW_W'((int'(base / NB) + ((b < int'(base_lo)) ? 1 : 0)) % ROWS);
      we    = in_acc && dec.wr_en && (int'(off) < int'(in_count));
      re    = in_acc && dec.rd_en;
      wbyte = 8'h00;
      if (int'(off) < LANES) begin
        wbyte = wr_data[8*int'(off) +: 8];
      end
    end

    brb_bank #(
      .ROWS  (ROWS),
      .ROW_W (ROW_W)
    ) u_bank (
      .clk   (clk),
      .we    (we),
      .waddr (row),
      .wdata (wbyte),
      .re    (re),
      .raddr (row),
      .rdata (bank_data[8*b +: 8])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_move) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ok_r    <= dec.ok;
      s1_rd_r    <= dec.rd_en;
      s1_rot_r   <= SEL_W'(rd_ptr % NB);
      s1_count_r <= in_count;
      s1_used_r  <= used_nxt;
      s1_free_r  <= free_nxt;
      s1_cfree_r <= cfree_nxt;
      s1_cused_r <= cused_nxt;
    end
  end

  brb_align #(
    .NB    (NB),
    .SEL_W (SEL_W),
    .LANES (LANES)
  ) u_align (
    .bank_data  (bank_data),
    .rot        (s1_rot_r),
    .count      (s1_count_r),
    .rd_en      (s1_rd_r),
    .read_bytes (rd_aligned)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_move) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_ok_r    <= s1_ok_r;
      out_rd_r    <= rd_aligned;
      out_used_r  <= s1_used_r;
      out_free_r  <= s1_free_r;
      out_cfree_r <= s1_cfree_r;
      out_cused_r <= s1_cused_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = OUT_TD_W'({out_cused_r, out_cfree_r, out_free_r, out_used_r, out_rd_r});

endmodule

>>> rtl/core/brb_checker.sv
module brb_checker
  import brb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int LANES = LANES_DEF,
  localparam int CNT_W    = $clog2(DEPTH) + 1,
  localparam int DW       = 8 * LANES,
  localparam int OUT_TD_W = ((DW + 4 * CNT_W + 7) / 8) * 8
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic                out_tuser,
  input logic [OUT_TD_W-1:0] out_tdata
);

  logic [DW-1:0]    rd_bytes;
  logic [CNT_W-1:0] used, free, cfree, cused;

  assign rd_bytes = out_tdata[DW-1:0];
  assign used     = out_tdata[DW +: CNT_W];
  assign free     = out_tdata[DW + CNT_W +: CNT_W];
  assign cfree    = out_tdata[DW + 2*CNT_W +: CNT_W];
  assign cused    = out_tdata[DW + 3*CNT_W +: CNT_W];

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_space_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(used) + 32'(free) == DEPTH))
    else $error("used and free counts do not add up to the depth");

  a_contig: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (cfree <= free) && (cused <= used))
    else $error("contiguous space exceeds total space");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (rd_bytes == '0))
    else $error("refused command returned data");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind byte_ring_buffer_unit brb_checker #(
  .DEPTH (DEPTH),
  .LANES (LANES)
) u_brb_checker (.*);

>>> bench/ring_checker.sv
module ring_checker
  import brb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int LANES = LANES_DEF,
  localparam int PTR_W    = $clog2(DEPTH) + 1,
  localparam int IDX_W    = $clog2(DEPTH),
  localparam int DW       = 8 * LANES,
  localparam int IN_TD_W  = ((CNT_FIELD_W + DW + 7) / 8) * 8,
  localparam int OUT_TD_W = ((DW + 4 * PTR_W + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [1:0]          in_tuser,
  input  logic [IN_TD_W-1:0]  in_tdata,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic                out_tuser,
  input  logic [OUT_TD_W-1:0] out_tdata,
  output int                  mismatches,
  output int                  outstanding
);

  typedef struct packed {
    logic             ok;
    logic [DW-1:0]    data;
    logic [PTR_W-1:0] held;
    logic [PTR_W-1:0] room;
    logic [PTR_W-1:0] room_to_wrap;
    logic [PTR_W-1:0] held_to_wrap;
  } ring_status_t;

  logic [7:0]       ring_bytes [DEPTH];
  logic [PTR_W-1:0] head_ptr;   // read side
  logic [PTR_W-1:0] tail_ptr;   // write side
  ring_status_t     expected_status [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    head_ptr    = '0;
    tail_ptr    = '0;
  end

  // Apply one command to the ring and return the status it reports.
  function automatic ring_status_t advance_ring(brb_cmd_t cmd, logic [3:0] n,
                                                logic [DW-1:0] wdata);
    ring_status_t     r;
    logic [PTR_W-1:0] held;
    logic [IDX_W-1:0] a;
    int               span;
    r    = '0;
    held = tail_ptr - head_ptr;
    if (cmd == CMD_CLEAR) begin
      head_ptr = '0;
      tail_ptr = '0;
      r.ok     = 1'b1;
    end else if (n == 4'd0) begin
      r.ok = 1'b1;
    end else if (int'(n) > LANES) begin
      r.ok = 1'b0;
    end else if (cmd == CMD_ENQ) begin
      if (DEPTH - int'(held) >= int'(n)) begin
        for (int i = 0; i < int'(n); i++) begin
          a = tail_ptr[IDX_W-1:0] + IDX_W'(i);
          ring_bytes[a] = wdata[8*i +: 8];
        end
        tail_ptr = tail_ptr + PTR_W'(n);
        r.ok     = 1'b1;
      end
    end else if (int'(held) >= int'(n)) begin
      for (int i = 0; i < int'(n); i++) begin
        a = head_ptr[IDX_W-1:0] + IDX_W'(i);
        r.data[8*i +: 8] = ring_bytes[a];
      end
      if (cmd == CMD_DEQ) head_ptr = head_ptr + PTR_W'(n);
      r.ok = 1'b1;
    end
    held   = tail_ptr - head_ptr;
    r.held = held;
    r.room = PTR_W'(DEPTH - int'(held));
    span   = DEPTH - int'(tail_ptr[IDX_W-1:0]);
    r.room_to_wrap = (int'(r.room) < span) ? r.room : PTR_W'(span);
    span   = DEPTH - int'(head_ptr[IDX_W-1:0]);
    r.held_to_wrap = (int'(held) < span) ? held : PTR_W'(span);
    return r;
  endfunction

  function automatic void check_field(string name, logic [DW-1:0] want, logic [DW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    ring_status_t want;
    if (!rst_n) begin
      head_ptr = '0;
      tail_ptr = '0;
      expected_status.delete();
    end else begin
      if (in_tvalid && in_tready)
        expected_status.push_back(advance_ring(brb_cmd_t'(in_tuser), in_tdata[3:0],
                                               in_tdata[CNT_FIELD_W +: DW]));
      if (out_tvalid && out_tready) begin
        if (expected_status.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h", $time,
                   out_tdata);
          mismatches++;
        end else begin
          want = expected_status.pop_front();
          check_field("accepted", DW'(want.ok), DW'(out_tuser));
          check_field("read_bytes", want.data, out_tdata[DW-1:0]);
          check_field("used_count", DW'(want.held), DW'(out_tdata[DW +: PTR_W]));
          check_field("free_count", DW'(want.room), DW'(out_tdata[DW+PTR_W +: PTR_W]));
          check_field("contiguous_free", DW'(want.room_to_wrap),
                      DW'(out_tdata[DW+2*PTR_W +: PTR_W]));
          check_field("contiguous_used", DW'(want.held_to_wrap),
                      DW'(out_tdata[DW+3*PTR_W +: PTR_W]));
        end
      end
    end
    outstanding = expected_status.size();
  end

endmodule

>>> bench/testbench.sv
module testbench;
  import brb_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int LANES      = LANES_DEF;
  localparam int PTR_W      = $clog2(DEPTH) + 1;
  localparam int DW         = 8 * LANES;
  localparam int IN_TD_W    = ((CNT_FIELD_W + DW + 7) / 8) * 8;
  localparam int OUT_TD_W   = ((DW + 4 * PTR_W + 7) / 8) * 8;
  localparam int RAND_WORDS = 1150;
  localparam int IDLE_LIMIT = 2000;   // far above the long output hold below
  localparam int HOLD_AT    = 600;    // result index where the consumer stalls hard
  localparam int HOLD_LEN   = 250;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [1:0]          in_tuser   = CMD_ENQ;    // cmd
  logic [IN_TD_W-1:0]  in_tdata   = '0;         // byte_count, write_bytes, zero pad
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic                out_tuser;               // accepted
  logic [OUT_TD_W-1:0] out_tdata;               // read_bytes, used_count, free_count,
                                                // contiguous_free, contiguous_used, pad
  int                  mismatches;
  int                  outstanding;
  int                  idle_cycles = 0;
  int                  words_sent  = 0;
  int                  words_taken = 0;

  always #10 clk = ~clk;

  byte_ring_buffer_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  ring_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tuser   (out_tuser),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Offer one command word after a random gap and hold it until it is taken.
  // Every fifth block of 100 words goes out back to back with no gap at all.
  task automatic send_word(brb_cmd_t cmd, logic [3:0] n, logic [DW-1:0] wdata);
    int gap;
    gap = ((words_sent / 100) % 5 == 4) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_TD_W - CNT_FIELD_W - DW){1'b0}}, wdata, n};
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // Draw a byte count: mostly legal sizes, some zero, some above the lane count.
  function automatic logic [3:0] draw_count();
    int k;
    k = $urandom_range(0, 99);
    if (k < 4) return 4'd0;
    if (k < 10) return 4'($urandom_range(LANES + 1, 15));
    return 4'($urandom_range(1, LANES));
  endfunction

  // Share of enqueues per phase: fill, hover, fill to full, churn with clears, drain.
  function automatic int enq_share(int idx);
    unique case (idx / 230)
      0: return 80;
      1: return 50;
      2: return 95;
      3: return 45;
      default: return 15;
    endcase
  endfunction

  // Consumer side: random stall before each result, one long hold that backs
  // the pipeline up into in_tready, and stretches taken at full rate.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      if (words_taken == HOLD_AT) stall = HOLD_LEN;
      else if ((words_taken / 90) % 5 == 2) stall = 0;
      else stall = $urandom_range(0, 13);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      words_taken++;
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("byte_ring_buffer_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [DW-1:0] ones;
    logic [3:0]    n;
    int            r;
    int            share;
    brb_cmd_t      cmd;
    ones = '1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-ring refusals, zero counts, oversize counts, full lanes,
    // clear with junk fields, reads right after a clear.
    send_word(CMD_ENQ,   4'd0,  ones);
    send_word(CMD_DEQ,   4'd1,  ones);
    send_word(CMD_PEEK,  4'd8,  '0);
    send_word(CMD_DEQ,   4'd0,  '0);
    send_word(CMD_PEEK,  4'd0,  ones);
    send_word(CMD_ENQ,   4'd8,  ones);
    send_word(CMD_ENQ,   4'd15, ones);
    send_word(CMD_ENQ,   4'd9,  {$urandom, $urandom});
    send_word(CMD_ENQ,   4'd8,  '0);
    send_word(CMD_PEEK,  4'd8,  ones);
    send_word(CMD_DEQ,   4'd8,  '0);
    send_word(CMD_PEEK,  4'd1,  '0);
    send_word(CMD_DEQ,   4'd9,  '0);
    send_word(CMD_ENQ,   4'd1,  64'h55aa_55aa_55aa_55aa);
    send_word(CMD_PEEK,  4'd15, '0);
    send_word(CMD_DEQ,   4'd8,  '0);
    send_word(CMD_CLEAR, 4'd15, ones);
    send_word(CMD_PEEK,  4'd1,  '0);
    send_word(CMD_ENQ,   4'd7,  {$urandom, $urandom});
    send_word(CMD_PEEK,  4'd7,  '0);
    send_word(CMD_DEQ,   4'd7,  ones);
    send_word(CMD_CLEAR, 4'd0,  '0);

    // Random: phases steer the fill level through empty, mid, full and wrap.
    for (int i = 0; i < RAND_WORDS; i++) begin
      share = enq_share(i);
      r     = $urandom_range(0, 99);
      if ((i / 230) == 3 && r < 3) cmd = CMD_CLEAR;
      else if (r < share) cmd = CMD_ENQ;
      else if ($urandom_range(0, 2) == 0) cmd = CMD_PEEK;
      else cmd = CMD_DEQ;
      n = draw_count();
      send_word(cmd, n, {$urandom, $urandom});
    end
    in_tvalid <= 1'b0;

    // Drain: let the checker see the last word, then wait out the pipeline.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("byte_ring_buffer_unit test passed");
    end else begin
      $display("byte_ring_buffer_unit test failed");
    end
    $finish;
  end

endmodule
